FILE: hw/rtl/bst_pkg.sv
`default_nettype none
package bst_pkg;

	localparam int MAX_NESTING = 32;
	localparam int NEST_W      = 6;
	localparam int STACK_AW    = $clog2(MAX_NESTING);
	localparam int ENTRY_W     = 2;

	// stack entry: bit 0 = dictionary, bit 1 = key seen, value awaited
	localparam logic [ENTRY_W-1:0] ENT_LIST    = 2'b00;
	localparam logic [ENTRY_W-1:0] ENT_DICT    = 2'b01;
	localparam logic [ENTRY_W-1:0] ENT_VAL_BIT = 2'b10;

	localparam logic [2:0] TK_INT       = 3'd0;
	localparam logic [2:0] TK_STR_START = 3'd1;
	localparam logic [2:0] TK_STR_BYTE  = 3'd2;
	localparam logic [2:0] TK_LIST      = 3'd3;
	localparam logic [2:0] TK_DICT      = 3'd4;
	localparam logic [2:0] TK_END       = 3'd5;
	localparam logic [2:0] TK_ERROR     = 3'd6;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_BAD_CHAR  = 3'd1;
	localparam logic [2:0] ERR_LEAD_ZERO = 3'd2;
	localparam logic [2:0] ERR_TRUNC     = 3'd3;
	localparam logic [2:0] ERR_TOO_DEEP  = 3'd4;
	localparam logic [2:0] ERR_OVERFLOW  = 3'd5;

	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

	typedef enum logic [5:0] {
		PH_VALUE     = 6'b000001,
		PH_INT_START = 6'b000010,
		PH_INT_BODY  = 6'b000100,
		PH_INT_ZERO  = 6'b001000,
		PH_STR_LEN   = 6'b010000,
		PH_STR_BODY  = 6'b100000
	} phase_t;

endpackage
`default_nettype wire

FILE: hw/rtl/bst_ram.sv
`default_nettype none
module bst_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: hw/rtl/bencode_stream_tokenizer_top.sv
`default_nettype none
// Bencode tokenizer: one stream byte per input word (byte_value, last_byte) on a
// valid/ready channel; at most one token word per input on the output channel
// (token_kind, is_key, token_value, nest_level, value_done, error_code).
// Integers come out at their closing 'e', strings as a start token with the
// length followed by one token per byte; 'l'/'d' give open tokens, 'e' an end.
// Each token is registered: it is presented the cycle after its byte is taken.
// Throughput: one byte per cycle unless the output stalls; each byte gets its
// parse step (compare, shift-add by ten, 68-bit limit compare) and any push/pop.
// The top of the container stack sits in a register; entries below it live in
// a small RAM with registered read that is always prefetched at the entry below
// the top, with a bypass for the cycle right after a push.
// Reset: asynchronous, returns to "expecting a new value" at depth 0; the
// stack RAM needs no clearing since only entries below the depth are read.
// Stall: the output word register holds while out_ready is low; a new byte is
// still taken in the same cycle the pending word is taken. Bytes that make no
// token pass through without touching the output.
// Any error token restarts parsing from an empty state.
module bencode_stream_tokenizer_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         byte_value,
	input  wire logic               last_byte,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [2:0]              token_kind,
	output logic                    is_key,
	output logic signed [63:0]      token_value,
	output logic [bst_pkg::NEST_W-1:0] nest_level,
	output logic                    value_done,
	output logic [2:0]              error_code
);

	localparam int NW = bst_pkg::NEST_W;
	localparam int AW = bst_pkg::STACK_AW;
	localparam int EW = bst_pkg::ENTRY_W;

	bst_pkg::phase_t phase_q, phase_d;
	logic [63:0]   acc_q, acc_d;
	logic          neg_q, neg_d;
	logic          has_dig_q, has_dig_d;
	logic [62:0]   left_q, left_d;
	logic [NW-1:0] nest_q, nest_d, nest_next;
	logic [EW-1:0] top_q, top_d;

	logic          fwd_q;
	logic [EW-1:0] fwd_data_q;
	logic [EW-1:0] ram_rdata;
	logic [EW-1:0] below;

	logic          out_valid_q;
	logic [2:0]    kind_q;
	logic          key_q;
	logic [63:0]   value_q;
	logic [NW-1:0] level_q;
	logic          done_q;
	logic [2:0]    err_q;

	logic          accept;
	logic          push;
	logic          emit;
	logic [2:0]    kind;
	logic          key;
	logic [63:0]   value;
	logic          done;
	logic [2:0]    err;

	logic          digit;
	logic [3:0]    dval;
	logic [67:0]   acc_x10;
	logic [63:0]   limit;
	logic          over;
	logic          in_dict;
	logic          want_key;
	logic          want_val;
	logic          cur_key;
	logic [AW-1:0] ram_raddr;
	logic [AW-1:0] ram_waddr;

	assign in_ready = out_ready || !out_valid_q;
	assign accept   = in_valid && in_ready;

	assign below = fwd_q ? fwd_data_q : ram_rdata;

	assign digit   = byte_value inside {[bst_pkg::CH_ZERO:bst_pkg::CH_NINE]};
	assign dval    = byte_value[3:0];
	assign limit   = (neg_q && phase_q != bst_pkg::PH_STR_LEN) ? bst_pkg::NEG_LIMIT
	                                                         : bst_pkg::POS_LIMIT;
	// acc*10 + d as (acc<<3) + (acc<<1) + d
	assign acc_x10 = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + {64'd0, dval};
	assign over    = acc_x10 > {4'd0, limit};

	assign in_dict  = (nest_q != '0) && top_q[0];
	assign want_key = in_dict && !top_q[1];
	assign want_val = in_dict && top_q[1];
	assign cur_key  = want_key;

	always_comb begin
		phase_d   = phase_q;
		acc_d     = acc_q;
		neg_d     = neg_q;
		has_dig_d = has_dig_q;
		left_d    = left_q;
		nest_d    = nest_q;
		top_d     = top_q;
		push      = 1'b0;
		emit      = 1'b0;
		kind      = bst_pkg::TK_INT;
		key       = 1'b0;
		value     = '0;
		done      = 1'b0;
		err       = bst_pkg::ERR_NONE;

		case (phase_q)
			bst_pkg::PH_VALUE: begin
				if (byte_value == bst_pkg::CH_E) begin
					if (nest_q == '0 || want_val) begin
						err = bst_pkg::ERR_BAD_CHAR;
					end else begin
						// pop: entry below becomes top, then the value it held ends
						nest_d = nest_q - NW'(1);
						top_d  = below;
						if (nest_d == '0) begin
							done = 1'b1;
						end else if (below[0]) begin
							top_d = below ^ bst_pkg::ENT_VAL_BIT;
						end
						emit = 1'b1;
						kind = bst_pkg::TK_END;
					end
				end else if (digit) begin
					acc_d   = {60'd0, dval};
					phase_d = bst_pkg::PH_STR_LEN;
				end else if (want_key) begin
					err = bst_pkg::ERR_BAD_CHAR;
				end else if (byte_value == bst_pkg::CH_I) begin
					acc_d     = '0;
					neg_d     = 1'b0;
					has_dig_d = 1'b0;
					phase_d   = bst_pkg::PH_INT_START;
				end else if (byte_value inside {bst_pkg::CH_L, bst_pkg::CH_D}) begin
					if (nest_q >= NW'(bst_pkg::MAX_NESTING)) begin
						err = bst_pkg::ERR_TOO_DEEP;
					end else begin
						push   = (nest_q != '0);
						top_d  = (byte_value == bst_pkg::CH_D) ? bst_pkg::ENT_DICT
						                                       : bst_pkg::ENT_LIST;
						nest_d = nest_q + NW'(1);
						emit   = 1'b1;
						kind   = (byte_value == bst_pkg::CH_D) ? bst_pkg::TK_DICT
						                                       : bst_pkg::TK_LIST;
					end
				end else begin
					err = bst_pkg::ERR_BAD_CHAR;
				end
			end
			bst_pkg::PH_INT_START, bst_pkg::PH_INT_BODY: begin
				if (phase_q == bst_pkg::PH_INT_START && byte_value == bst_pkg::CH_MINUS) begin
					neg_d   = 1'b1;
					phase_d = bst_pkg::PH_INT_BODY;
				end else if (byte_value == bst_pkg::CH_ZERO && !has_dig_q) begin
					if (neg_q) begin
						err = bst_pkg::ERR_LEAD_ZERO;
					end else begin
						phase_d = bst_pkg::PH_INT_ZERO;
					end
				end else if (digit) begin
					if (over) begin
						err = bst_pkg::ERR_OVERFLOW;
					end else begin
						acc_d     = acc_x10[63:0];
						has_dig_d = 1'b1;
						phase_d   = bst_pkg::PH_INT_BODY;
					end
				end else if (byte_value == bst_pkg::CH_E && has_dig_q) begin
					phase_d = bst_pkg::PH_VALUE;
					emit    = 1'b1;
					kind    = bst_pkg::TK_INT;
					value   = neg_q ? (64'd0 - acc_q) : acc_q;
					if (nest_q == '0) begin
						done = 1'b1;
					end else if (top_q[0]) begin
						top_d = top_q ^ bst_pkg::ENT_VAL_BIT;
					end
				end else begin
					err = bst_pkg::ERR_BAD_CHAR;
				end
			end
			bst_pkg::PH_INT_ZERO: begin
				if (byte_value == bst_pkg::CH_E) begin
					phase_d = bst_pkg::PH_VALUE;
					emit    = 1'b1;
					kind    = bst_pkg::TK_INT;
					if (nest_q == '0) begin
						done = 1'b1;
					end else if (top_q[0]) begin
						top_d = top_q ^ bst_pkg::ENT_VAL_BIT;
					end
				end else begin
					err = bst_pkg::ERR_LEAD_ZERO;
				end
			end
			bst_pkg::PH_STR_LEN: begin
				if (digit) begin
					if (over) begin
						err = bst_pkg::ERR_OVERFLOW;
					end else begin
						acc_d = acc_x10[63:0];
					end
				end else if (byte_value == bst_pkg::CH_COLON) begin
					left_d = acc_q[62:0];
					emit   = 1'b1;
					kind   = bst_pkg::TK_STR_START;
					key    = cur_key;
					value  = acc_q;
					if (acc_q == '0) begin
						phase_d = bst_pkg::PH_VALUE;
						if (nest_q == '0) begin
							done = 1'b1;
						end else if (top_q[0]) begin
							top_d = top_q ^ bst_pkg::ENT_VAL_BIT;
						end
					end else begin
						phase_d = bst_pkg::PH_STR_BODY;
					end
				end else begin
					err = bst_pkg::ERR_BAD_CHAR;
				end
			end
			bst_pkg::PH_STR_BODY: begin
				left_d = left_q - 63'd1;
				emit   = 1'b1;
				kind   = bst_pkg::TK_STR_BYTE;
				key    = cur_key;
				value  = {56'd0, byte_value};
				if (left_d == '0) begin
					phase_d = bst_pkg::PH_VALUE;
					if (nest_q == '0) begin
						done = 1'b1;
					end else if (top_q[0]) begin
						top_d = top_q ^ bst_pkg::ENT_VAL_BIT;
					end
				end
			end
			default: begin
				err = bst_pkg::ERR_BAD_CHAR;
			end
		endcase

		if (err == bst_pkg::ERR_NONE && last_byte &&
		    !(phase_d == bst_pkg::PH_VALUE && nest_d == '0)) begin
			err = bst_pkg::ERR_TRUNC;
		end

		if (err != bst_pkg::ERR_NONE) begin
			phase_d   = bst_pkg::PH_VALUE;
			acc_d     = '0;
			neg_d     = 1'b0;
			has_dig_d = 1'b0;
			left_d    = '0;
			nest_d    = '0;
			push      = 1'b0;
			emit      = 1'b1;
			kind      = bst_pkg::TK_ERROR;
			key       = 1'b0;
			value     = '0;
			done      = 1'b0;
		end
	end

	// prefetch the entry just below the next top
	assign nest_next = accept ? nest_d : nest_q;
	assign ram_raddr = AW'(nest_next - NW'(2));
	assign ram_waddr = AW'(nest_q - NW'(1));

	bst_ram #(
		.WIDTH(EW),
		.DEPTH(bst_pkg::MAX_NESTING)
	) u_stack_ram (
		.clk  (clk),
		.we   (accept && push),
		.waddr(ram_waddr),
		.wdata(top_q),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= bst_pkg::PH_VALUE;
			acc_q       <= '0;
			neg_q       <= 1'b0;
			has_dig_q   <= 1'b0;
			left_q      <= '0;
			nest_q      <= '0;
			top_q       <= bst_pkg::ENT_LIST;
			fwd_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a push writes the old top at the address read this cycle
			fwd_q <= accept && push;
			if (accept) begin
				phase_q     <= phase_d;
				acc_q       <= acc_d;
				neg_q       <= neg_d;
				has_dig_q   <= has_dig_d;
				left_q      <= left_d;
				nest_q      <= nest_d;
				top_q       <= top_d;
				out_valid_q <= emit;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= top_q;
		if (accept && emit) begin
			kind_q  <= kind;
			key_q   <= key;
			value_q <= value;
			level_q <= nest_d;
			done_q  <= done;
			err_q   <= err;
		end
	end

	assign out_valid   = out_valid_q;
	assign token_kind  = kind_q;
	assign is_key      = key_q;
	assign token_value = value_q;
	assign nest_level  = level_q;
	assign value_done  = done_q;
	assign error_code  = err_q;

endmodule
`default_nettype wire
